FILE: hw/rtl/mtps_pkg.sv
// Shared types, constants and helper functions for the motor test phase sequencer.
package mtps_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int DUTY_WIDTH = 16;
   localparam int MS_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [TIME_WIDTH-1:0]        time_type;
   typedef logic signed [DUTY_WIDTH-1:0] duty_type;
   typedef logic [MS_WIDTH-1:0]          ms_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]   csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]    csr_data_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEFT   = 3'd1,
      PH_COAST1 = 3'd2,
      PH_RIGHT  = 3'd3,
      PH_COAST2 = 3'd4,
      PH_SWEEP  = 3'd5
   } phase_type;

   // Register indexes on the csr port
   localparam csr_index_type CSR_DRIVE_TIME    = 3'd0;
   localparam csr_index_type CSR_COAST_TIME    = 3'd1;
   localparam csr_index_type CSR_SWEEP_TIME    = 3'd2;
   localparam csr_index_type CSR_PULSE_TIME    = 3'd3;
   localparam csr_index_type CSR_LEFT_REVERSE  = 3'd4;
   localparam csr_index_type CSR_RIGHT_REVERSE = 3'd5;
   localparam csr_index_type CSR_SWEEP_REVERSE = 3'd6;

   localparam ms_type DRIVE_TIME_RESET = 16'd2000;
   localparam ms_type COAST_TIME_RESET = 16'd1000;
   localparam ms_type SWEEP_TIME_RESET = 16'd3000;
   localparam ms_type PULSE_TIME_RESET = 16'd0;

   localparam duty_type DUTY_MAX  = {1'b0, {(DUTY_WIDTH-1){1'b1}}};
   localparam duty_type DUTY_MIN  = {1'b1, {(DUTY_WIDTH-1){1'b0}}};
   localparam duty_type DUTY_ZERO = '0;

   // Negate when reversed; the most negative value saturates to full forward.
   function automatic duty_type apply_dir(duty_type v, logic rev);
      duty_type r;
      if (!rev) begin
         r = v;
      end else if (v == DUTY_MIN) begin
         r = DUTY_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // Deadline wraps at the time width.
   function automatic time_type deadline_after(time_type now, ms_type dur);
      return now + time_type'(dur);
   endfunction

endpackage

FILE: hw/rtl/motor_test_phase_sequencer.sv
// Top level of the motor test phase sequencer: tick register, phase update, result register.
//
// One control tick word in, one result word out. The block accepts a tick word
// in every cycle when the result side keeps up; a word lands in the tick register,
// the phase and pulse update runs in one pass of compares and adds against the
// held state, and the result register shows the outcome. The tick register and
// the result register each hold one word, so a stalled result side backs up by at
// most two words before req_ready drops. A sequence request while idle starts the
// diagnostic run: left wheel full speed, braked coast, right wheel, braked coast,
// sweep motor, idle; rsp_sequence_finished marks the tick the run ends so the host
// can drop its request. While idle a pulse request drives the manual duties until
// the pulse deadline and then brakes; otherwise the duties pass straight through.
// Deadlines are now plus the duration, wrapped at the time width, and are compared
// with no wrap handling. Write the csr registers only while no tick is in flight;
// csr_ready is always high.
module motor_test_phase_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   // tick input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mtps_pkg::time_type       req_now_ms,
   input  logic                     req_sequence_request,
   input  logic                     req_pulse_request,
   input  mtps_pkg::duty_type       req_duty_left,
   input  mtps_pkg::duty_type       req_duty_right,
   input  mtps_pkg::duty_type       req_duty_sweep,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_phase,
   output logic                     rsp_pulsing,
   output mtps_pkg::duty_type       rsp_drive_left,
   output mtps_pkg::duty_type       rsp_drive_right,
   output mtps_pkg::duty_type       rsp_drive_sweep,
   output logic                     rsp_braked,
   output logic                     rsp_sequence_finished,
   output logic                     rsp_pulse_finished,
   output logic                     rsp_pulse_started,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  mtps_pkg::csr_index_type  csr_index,
   input  mtps_pkg::csr_data_type   csr_data
);

   // configuration registers
   mtps_pkg::ms_type drive_time_ff, coast_time_ff, sweep_time_ff, pulse_time_ff;
   logic             left_rev_ff, right_rev_ff, sweep_rev_ff;

   // tick register
   logic                in_valid_ff;
   mtps_pkg::time_type  in_now_ff;
   logic                in_seq_ff, in_pul_ff;
   mtps_pkg::duty_type  in_left_ff, in_right_ff, in_sweep_ff;

   // sequencer state
   mtps_pkg::phase_type phase_ff, phase_in;
   mtps_pkg::time_type  phase_deadline_ff, phase_deadline_in;
   logic                pulse_active_ff, pulse_active_in;
   mtps_pkg::time_type  pulse_deadline_ff, pulse_deadline_in;
   mtps_pkg::duty_type  left_cmd_ff, left_cmd_in;
   mtps_pkg::duty_type  right_cmd_ff, right_cmd_in;
   mtps_pkg::duty_type  sweep_cmd_ff, sweep_cmd_in;
   logic                brake_ff, brake_in;
   logic                seq_done, pul_done, pul_start;

   logic advance;

   // Move the held tick into the result register when that register frees up.
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_time_ff <= mtps_pkg::DRIVE_TIME_RESET;
         coast_time_ff <= mtps_pkg::COAST_TIME_RESET;
         sweep_time_ff <= mtps_pkg::SWEEP_TIME_RESET;
         pulse_time_ff <= mtps_pkg::PULSE_TIME_RESET;
         left_rev_ff   <= 1'b0;
         right_rev_ff  <= 1'b0;
         sweep_rev_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mtps_pkg::CSR_DRIVE_TIME:    drive_time_ff <= csr_data;
            mtps_pkg::CSR_COAST_TIME:    coast_time_ff <= csr_data;
            mtps_pkg::CSR_SWEEP_TIME:    sweep_time_ff <= csr_data;
            mtps_pkg::CSR_PULSE_TIME:    pulse_time_ff <= csr_data;
            mtps_pkg::CSR_LEFT_REVERSE:  left_rev_ff   <= csr_data[0];
            mtps_pkg::CSR_RIGHT_REVERSE: right_rev_ff  <= csr_data[0];
            mtps_pkg::CSR_SWEEP_REVERSE: sweep_rev_ff  <= csr_data[0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // Tick register: load whenever the handshake completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_now_ff   <= req_now_ms;
         in_seq_ff   <= req_sequence_request;
         in_pul_ff   <= req_pulse_request;
         in_left_ff  <= req_duty_left;
         in_right_ff <= req_duty_right;
         in_sweep_ff <= req_duty_sweep;
      end
   end

   // One tick of the sequencer: start, phase advance, then idle pulse handling.
   always_comb begin
      phase_in          = (phase_ff > mtps_pkg::PH_SWEEP) ? mtps_pkg::PH_IDLE : phase_ff;
      phase_deadline_in = phase_deadline_ff;
      pulse_active_in   = pulse_active_ff;
      pulse_deadline_in = pulse_deadline_ff;
      left_cmd_in       = left_cmd_ff;
      right_cmd_in      = right_cmd_ff;
      sweep_cmd_in      = sweep_cmd_ff;
      brake_in          = brake_ff;
      seq_done          = 1'b0;
      pul_done          = 1'b0;
      pul_start         = 1'b0;

      // start the run from idle
      if (in_seq_ff && phase_in == mtps_pkg::PH_IDLE) begin
         phase_in          = mtps_pkg::PH_LEFT;
         phase_deadline_in = mtps_pkg::deadline_after(in_now_ff, drive_time_ff);
         left_cmd_in       = mtps_pkg::apply_dir(mtps_pkg::DUTY_MAX, left_rev_ff);
         right_cmd_in      = mtps_pkg::DUTY_ZERO;
         sweep_cmd_in      = mtps_pkg::DUTY_ZERO;
         brake_in          = 1'b0;
      end

      // advance when the phase deadline is reached
      if (phase_in != mtps_pkg::PH_IDLE && in_now_ff >= phase_deadline_in) begin
         unique case (phase_in)
            mtps_pkg::PH_LEFT, mtps_pkg::PH_RIGHT: begin
               phase_in = (phase_in == mtps_pkg::PH_LEFT) ? mtps_pkg::PH_COAST1
                                                          : mtps_pkg::PH_COAST2;
               phase_deadline_in = mtps_pkg::deadline_after(in_now_ff, coast_time_ff);
               left_cmd_in  = mtps_pkg::DUTY_ZERO;
               right_cmd_in = mtps_pkg::DUTY_ZERO;
               sweep_cmd_in = mtps_pkg::DUTY_ZERO;
               brake_in     = 1'b1;
            end
            mtps_pkg::PH_COAST1: begin
               phase_in          = mtps_pkg::PH_RIGHT;
               phase_deadline_in = mtps_pkg::deadline_after(in_now_ff, drive_time_ff);
               left_cmd_in       = mtps_pkg::DUTY_ZERO;
               right_cmd_in      = mtps_pkg::apply_dir(mtps_pkg::DUTY_MAX, right_rev_ff);
               sweep_cmd_in      = mtps_pkg::DUTY_ZERO;
               brake_in          = 1'b0;
            end
            mtps_pkg::PH_COAST2: begin
               phase_in          = mtps_pkg::PH_SWEEP;
               phase_deadline_in = mtps_pkg::deadline_after(in_now_ff, sweep_time_ff);
               left_cmd_in       = mtps_pkg::DUTY_ZERO;
               right_cmd_in      = mtps_pkg::DUTY_ZERO;
               sweep_cmd_in      = mtps_pkg::apply_dir(mtps_pkg::DUTY_MAX, sweep_rev_ff);
               brake_in          = 1'b0;
            end
            default: begin
               // end of the sweep: back to idle with a brake
               phase_in     = mtps_pkg::PH_IDLE;
               left_cmd_in  = mtps_pkg::DUTY_ZERO;
               right_cmd_in = mtps_pkg::DUTY_ZERO;
               sweep_cmd_in = mtps_pkg::DUTY_ZERO;
               brake_in     = 1'b1;
               seq_done     = 1'b1;
            end
         endcase
      end

      // idle: pulse handling and pass-through; a running pulse freezes during a run
      if (phase_in == mtps_pkg::PH_IDLE) begin
         if (in_pul_ff && !pulse_active_in) begin
            pulse_active_in   = 1'b1;
            pulse_deadline_in = mtps_pkg::deadline_after(in_now_ff, pulse_time_ff);
            left_cmd_in       = mtps_pkg::apply_dir(in_left_ff, left_rev_ff);
            right_cmd_in      = mtps_pkg::apply_dir(in_right_ff, right_rev_ff);
            sweep_cmd_in      = mtps_pkg::apply_dir(in_sweep_ff, sweep_rev_ff);
            brake_in          = 1'b0;
            pul_start         = 1'b1;
         end
         if (pulse_active_in && in_now_ff >= pulse_deadline_in) begin
            left_cmd_in     = mtps_pkg::DUTY_ZERO;
            right_cmd_in    = mtps_pkg::DUTY_ZERO;
            sweep_cmd_in    = mtps_pkg::DUTY_ZERO;
            brake_in        = 1'b1;
            pulse_active_in = 1'b0;
            pul_done        = 1'b1;
         end
         if (!pulse_active_in && !in_pul_ff) begin
            left_cmd_in  = mtps_pkg::apply_dir(in_left_ff, left_rev_ff);
            right_cmd_in = mtps_pkg::apply_dir(in_right_ff, right_rev_ff);
            sweep_cmd_in = mtps_pkg::apply_dir(in_sweep_ff, sweep_rev_ff);
            brake_in     = 1'b0;
         end
      end
   end

   // Commit state and load the result register on advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= mtps_pkg::PH_IDLE;
         phase_deadline_ff <= '0;
         pulse_active_ff   <= 1'b0;
         pulse_deadline_ff <= '0;
         left_cmd_ff       <= mtps_pkg::DUTY_ZERO;
         right_cmd_ff      <= mtps_pkg::DUTY_ZERO;
         sweep_cmd_ff      <= mtps_pkg::DUTY_ZERO;
         brake_ff          <= 1'b0;
         rsp_valid         <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff          <= phase_in;
            phase_deadline_ff <= phase_deadline_in;
            pulse_active_ff   <= pulse_active_in;
            pulse_deadline_ff <= pulse_deadline_in;
            left_cmd_ff       <= left_cmd_in;
            right_cmd_ff      <= right_cmd_in;
            sweep_cmd_ff      <= sweep_cmd_in;
            brake_ff          <= brake_in;
            rsp_valid         <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid         <= 1'b0;
         end
      end
      if (advance) begin
         rsp_phase             <= phase_in;
         rsp_pulsing           <= pulse_active_in;
         rsp_drive_left        <= left_cmd_in;
         rsp_drive_right       <= right_cmd_in;
         rsp_drive_sweep       <= sweep_cmd_in;
         rsp_braked            <= brake_in;
         rsp_sequence_finished <= seq_done;
         rsp_pulse_finished    <= pul_done;
         rsp_pulse_started     <= pul_start;
      end
   end

endmodule
